>>> rtl/core/mwu_pkg.sv
// Package: widths, constants, opcodes and controller/datapath link types.
`default_nettype none
package mwu_pkg;

    localparam int VAL_W    = 32;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 5;
    localparam int CI_W     = 6;
    localparam int PRIOR_W  = 32;
    localparam int STEP_W   = 17;
    localparam int WEIGHT_W = 25;
    localparam int IDX_W    = 6;
    localparam int RHO_W    = 47;
    localparam int VIOL_W   = 48;
    localparam int CNT_W    = 7;
    localparam int W_W      = 33;
    localparam int SUM_W    = 40;
    localparam int DVD_W    = 64;
    localparam int DSR_W    = 48;
    localparam int FRAC_W   = 24;

    localparam logic [STEP_W-1:0] STEP_RESET = 17'd6554;
    localparam logic [STEP_W-1:0] EPS_MAX    = 17'd65536;
    localparam logic [RHO_W-1:0]  RHO_MAX    = {RHO_W{1'b1}};

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_TERM   = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_MAT_WR,
        DP_RD_ITEM,
        DP_TERM_MUL,
        DP_TERM_WR,
        DP_CLOSE_WR,
        DP_MAX_RD,
        DP_MAX_UPD,
        DP_RHO,
        DP_W_RD,
        DP_W_MUL,
        DP_W_DIV,
        DP_W_F,
        DP_W_P,
        DP_O_RD,
        DP_O_DIV,
        DP_O_LOAD,
        DP_CLEAR
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
        logic    in_ready;
    } ctrl_t;

    typedef struct packed {
        op_t  op;
        logic count_zero;
        logic idx_last;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/mwu_if.sv
// Interfaces: input item channel and result item channel.
`default_nettype none
interface mwu_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic [4:0]                row;
    logic [4:0]                col;
    logic signed [31:0]        value;
    logic [5:0]                constraint_index;
    logic [31:0]               prior_weight;

    modport source (output valid, op, row, col, value, constraint_index, prior_weight,
                    input ready);
    modport sink   (input valid, op, row, col, value, constraint_index, prior_weight,
                    output ready);
endinterface

interface mwu_out_if;
    logic                      valid;
    logic                      ready;
    logic [24:0]               weight;
    logic [5:0]                weight_index;
    logic [46:0]               max_violation;
    logic                      last;

    modport source (output valid, weight, weight_index, max_violation, last,
                    input ready);
    modport sink   (input valid, weight, weight_index, max_violation, last,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/core/multiplicative_weight_update.sv
// Top level: multiplicative weight update over sparse constraint violations.
//
// channel    kind         handshake      payload
// items      input item   valid/ready    op row col value constraint_index prior_weight
// results    result item  valid/ready    weight weight_index max_violation last
// cfg        step_size    cfg_we         cfg_wdata
//
// Load, sparse term and close each run one item at a time via the controller.
// Finish with n constraints runs the 64-step divider once per new weight and once per
// normalized weight.
// Reset clears control state and the violation valid bits and sets step_size to its reset value at once.
// A stalled result holds the output register and the finish sweep waits behind it.
`default_nettype none
module multiplicative_weight_update #(
    parameter int NUM_CONSTRAINTS = 64,
    parameter int MATRIX_DIM      = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    mwu_in_if.sink                     items,
    mwu_out_if.source                  results,
    input  logic                       cfg_we,
    input  logic [mwu_pkg::STEP_W-1:0] cfg_wdata
);
    import mwu_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    mwu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    mwu_datapath #(
        .NUM_CONSTRAINTS (NUM_CONSTRAINTS),
        .MATRIX_DIM      (MATRIX_DIM)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .stat      (stat)
    );
endmodule
`default_nettype wire

>>> rtl/core/mwu_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module mwu_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mwu_pkg::DVD_W-1:0] dividend,
    input  logic [mwu_pkg::DSR_W-1:0] divisor,
    output logic                      done,
    output logic [mwu_pkg::DVD_W-1:0] quotient
);
    import mwu_pkg::*;

    localparam int CNT_BITS = $clog2(DVD_W);
    localparam logic [CNT_BITS-1:0] CNT_END = CNT_BITS'(DVD_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [DSR_W-1:0]    rem_reg, rem_next;
    logic [DSR_W-1:0]    dsr_reg, dsr_next;
    logic [DSR_W-1:0]    rem_sh;
    logic                ge;

    assign rem_sh = {rem_reg[DSR_W-2:0], dvd_reg[DVD_W-1]};
    assign ge     = rem_sh >= dsr_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_sh - dsr_reg) : rem_sh;
            dvd_next = {dvd_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_END)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;
endmodule
`default_nettype wire

>>> rtl/core/mwu_datapath.sv
// Datapath: stores, multipliers, accumulators, divider and output register.
`default_nettype none
module mwu_datapath #(
    parameter int NUM_CONSTRAINTS = 64,
    parameter int MATRIX_DIM      = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    mwu_in_if.sink                     items,
    mwu_out_if.source                  results,
    input  logic                       cfg_we,
    input  logic [mwu_pkg::STEP_W-1:0] cfg_wdata,
    input  mwu_pkg::ctrl_t             ctrl,
    output mwu_pkg::stat_t             stat
);
    import mwu_pkg::*;

    localparam int CW     = (NUM_CONSTRAINTS > 1) ? $clog2(NUM_CONSTRAINTS) : 1;
    localparam int MDEPTH = MATRIX_DIM * MATRIX_DIM;
    localparam int AW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

    function automatic logic signed [VIOL_W-1:0] sat48(input logic signed [VIOL_W:0] s);
        logic signed [VIOL_W-1:0] r;
        if (s[VIOL_W] != s[VIOL_W-1])
            r = s[VIOL_W] ? {1'b1, {(VIOL_W-1){1'b0}}} : {1'b0, {(VIOL_W-1){1'b1}}};
        else
            r = s[VIOL_W-1:0];
        return r;
    endfunction

    logic                     accept;
    logic [1:0]               op_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [COL_W-1:0]         col_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic [CI_W-1:0]          ci_reg;
    logic [PRIOR_W-1:0]       prior_reg;
    logic                     rc_ok, ci_ok;
    logic [AW-1:0]            mat_addr;
    logic [CW-1:0]            ci_addr;

    logic [VAL_W-1:0]         mat_mem [MDEPTH];
    logic [VAL_W-1:0]         mat_q;
    logic [VIOL_W-1:0]        viol_mem [NUM_CONSTRAINTS];
    logic [VIOL_W-1:0]        viol_q;
    logic                     vq_valid;
    logic [NUM_CONSTRAINTS-1:0] vvalid_reg;
    logic [PRIOR_W-1:0]       prior_mem [NUM_CONSTRAINTS];
    logic [PRIOR_W-1:0]       prior_q;
    logic [W_W-1:0]           w_mem [NUM_CONSTRAINTS];
    logic [W_W-1:0]           w_q;

    logic [CW-1:0]            viol_addr;
    logic                     viol_rd, viol_wr;
    logic signed [VIOL_W-1:0] viol_eff, viol_wdata;
    logic signed [VAL_W-1:0]  x_val;
    logic signed [DVD_W-1:0]  prod_reg;
    logic signed [VIOL_W-1:0] term;
    logic [VIOL_W-1:0]        viol_abs;

    logic [STEP_W-1:0]        step_reg;
    logic [STEP_W-1:0]        eps;
    logic [CNT_W-1:0]         count_reg;
    logic [CW-1:0]            idx_reg;
    logic                     idx_last, idx_adv;
    logic [VIOL_W-1:0]        maxabs_reg;
    logic [VIOL_W:0]          rho_ext;
    logic [RHO_W-1:0]         rho_reg;
    logic signed [DVD_W-1:0]  t_reg;
    logic [DVD_W-1:0]         t_abs;
    logic [16:0]              q_mag;
    logic [17:0]              f_val;
    logic [49:0]              p_reg;
    logic [W_W-1:0]           w_new;
    logic [SUM_W-1:0]         sum_reg;

    logic                     div_start, div_done;
    logic [DVD_W-1:0]         div_dvd, div_q;
    logic [DSR_W-1:0]         div_dsr;

    logic                     out_valid_reg, out_free;
    logic [WEIGHT_W-1:0]      out_w_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic [RHO_W-1:0]         out_rho_reg;
    logic                     out_last_reg;

    assign items.ready = ctrl.in_ready;
    assign accept      = items.valid && ctrl.in_ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= items.op;
            row_reg   <= items.row;
            col_reg   <= items.col;
            val_reg   <= items.value;
            ci_reg    <= items.constraint_index;
            prior_reg <= items.prior_weight;
        end
    end

    assign rc_ok    = (int'(row_reg) < MATRIX_DIM) && (int'(col_reg) < MATRIX_DIM);
    assign ci_ok    = int'(ci_reg) < NUM_CONSTRAINTS;
    assign mat_addr = AW'(int'(row_reg) * MATRIX_DIM + int'(col_reg));
    assign ci_addr  = CW'(ci_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.cmd == DP_MAT_WR && rc_ok)
            mat_mem[mat_addr] <= val_reg;
        if (ctrl.cmd == DP_RD_ITEM)
            mat_q <= mat_mem[mat_addr];
    end

    assign viol_rd   = (ctrl.cmd == DP_RD_ITEM) || (ctrl.cmd == DP_MAX_RD) ||
                       (ctrl.cmd == DP_W_RD);
    assign viol_wr   = ((ctrl.cmd == DP_TERM_WR) || (ctrl.cmd == DP_CLOSE_WR)) && ci_ok;
    assign viol_addr = ((ctrl.cmd == DP_MAX_RD) || (ctrl.cmd == DP_W_RD)) ? idx_reg : ci_addr;
    assign viol_eff  = vq_valid ? viol_q : '0;

    always_ff @(posedge clk)
    begin
        if (viol_wr)
            viol_mem[viol_addr] <= viol_wdata;
        if (viol_rd)
        begin
            viol_q   <= viol_mem[viol_addr];
            vq_valid <= vvalid_reg[viol_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vvalid_reg <= '0;
        else if (ctrl.cmd == DP_CLEAR)
            vvalid_reg <= '0;
        else if (viol_wr)
            vvalid_reg[viol_addr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmd == DP_CLOSE_WR && ci_ok)
            prior_mem[ci_addr] <= prior_reg;
        if (ctrl.cmd == DP_W_RD)
            prior_q <= prior_mem[idx_reg];
        if (ctrl.cmd == DP_W_P)
            w_mem[idx_reg] <= w_new;
        if (ctrl.cmd == DP_O_RD)
            w_q <= w_mem[idx_reg];
    end

    assign x_val = rc_ok ? $signed(mat_q) : '0;
    assign term  = prod_reg[DVD_W-1:16];

    always_ff @(posedge clk)
    begin
        if (ctrl.cmd == DP_TERM_MUL)
            prod_reg <= val_reg * x_val;
    end

    always_comb
    begin
        if (ctrl.cmd == DP_TERM_WR)
            viol_wdata = sat48({viol_eff[VIOL_W-1], viol_eff} + {term[VIOL_W-1], term});
        else
            viol_wdata = sat48({viol_eff[VIOL_W-1], viol_eff} -
                               {{(VIOL_W+1-VAL_W){val_reg[VAL_W-1]}}, val_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_RESET;
        else if (cfg_we)
            step_reg <= cfg_wdata;
    end

    assign eps = (step_reg > EPS_MAX) ? EPS_MAX : step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.cmd == DP_CLEAR)
            count_reg <= '0;
        else if (ctrl.cmd == DP_CLOSE_WR && ci_ok && ({1'b0, ci_reg} + 7'd1 > count_reg))
            count_reg <= {1'b0, ci_reg} + 7'd1;
    end

    assign idx_last = (CNT_W'(idx_reg) + 7'd1) == count_reg;
    assign idx_adv  = (ctrl.cmd == DP_MAX_UPD) || (ctrl.cmd == DP_W_P) ||
                      ((ctrl.cmd == DP_O_LOAD) && out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (accept)
            idx_reg <= '0;
        else if (idx_adv)
            idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
    end

    assign viol_abs = viol_eff[VIOL_W-1] ? (VIOL_W'(0) - viol_eff) : viol_eff;
    assign rho_ext  = {1'b0, maxabs_reg} + 1'b1;
    assign t_abs    = t_reg[DVD_W-1] ? (DVD_W'(0) - t_reg) : t_reg;
    assign q_mag    = div_q[16:0];
    assign f_val    = t_reg[DVD_W-1] ? (18'd65536 + {1'b0, q_mag}) : (18'd65536 - {1'b0, q_mag});
    assign w_new    = (p_reg[48:16] == '0) ? W_W'(1) : p_reg[48:16];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            maxabs_reg <= '0;
            sum_reg    <= '0;
        end
        if (ctrl.cmd == DP_MAX_UPD && viol_abs > maxabs_reg)
            maxabs_reg <= viol_abs;
        if (ctrl.cmd == DP_RHO)
            rho_reg <= (rho_ext > {2'b00, RHO_MAX}) ? RHO_MAX : rho_ext[RHO_W-1:0];
        if (ctrl.cmd == DP_W_MUL)
            t_reg <= viol_eff * $signed({1'b0, eps});
        if (ctrl.cmd == DP_W_F)
            p_reg <= prior_q * f_val;
        if (ctrl.cmd == DP_W_P)
            sum_reg <= sum_reg + SUM_W'(w_new);
    end

    assign div_start = (ctrl.cmd == DP_W_DIV) || (ctrl.cmd == DP_O_DIV);
    assign div_dvd   = (ctrl.cmd == DP_W_DIV) ? t_abs : DVD_W'({w_q, {FRAC_W{1'b0}}});
    assign div_dsr   = (ctrl.cmd == DP_W_DIV) ? DSR_W'(rho_reg) : DSR_W'(sum_reg);

    mwu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.cmd == DP_O_LOAD && out_free)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmd == DP_O_LOAD && out_free)
        begin
            out_w_reg    <= div_q[WEIGHT_W-1:0];
            out_idx_reg  <= IDX_W'(idx_reg);
            out_rho_reg  <= rho_reg;
            out_last_reg <= idx_last;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.weight        = out_w_reg;
    assign results.weight_index  = out_idx_reg;
    assign results.max_violation = out_rho_reg;
    assign results.last          = out_last_reg;

    assign stat.op         = op_t'(op_reg);
    assign stat.count_zero = count_reg == '0;
    assign stat.idx_last   = idx_last;
    assign stat.div_done   = div_done;
    assign stat.out_free   = out_free;
endmodule
`default_nettype wire

>>> rtl/core/mwu_ctrl.sv
// Controller: sequences the datapath for each operation and the finish sweep.
`default_nettype none
module mwu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  mwu_pkg::stat_t stat,
    output mwu_pkg::ctrl_t ctrl
);
    import mwu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_MAT_WR, S_TERM_RD, S_TERM_MUL, S_TERM_WR,
        S_CLOSE_RD, S_CLOSE_WR, S_MAX_RD, S_MAX_UPD, S_RHO,
        S_W_RD, S_W_MUL, S_W_DIV, S_W_WAIT, S_W_F, S_W_P,
        S_O_RD, S_O_DIV, S_O_WAIT, S_O_LOAD, S_CLEAR
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_LOAD:  state_next = S_MAT_WR;
                    OP_TERM:  state_next = S_TERM_RD;
                    OP_CLOSE: state_next = S_CLOSE_RD;
                    default:  state_next = stat.count_zero ? S_CLEAR : S_MAX_RD;
                endcase
            end
            S_MAT_WR:   state_next = S_IDLE;
            S_TERM_RD:  state_next = S_TERM_MUL;
            S_TERM_MUL: state_next = S_TERM_WR;
            S_TERM_WR:  state_next = S_IDLE;
            S_CLOSE_RD: state_next = S_CLOSE_WR;
            S_CLOSE_WR: state_next = S_IDLE;
            S_MAX_RD:   state_next = S_MAX_UPD;
            S_MAX_UPD:  state_next = stat.idx_last ? S_RHO : S_MAX_RD;
            S_RHO:      state_next = S_W_RD;
            S_W_RD:     state_next = S_W_MUL;
            S_W_MUL:    state_next = S_W_DIV;
            S_W_DIV:    state_next = S_W_WAIT;
            S_W_WAIT:   if (stat.div_done) state_next = S_W_F;
            S_W_F:      state_next = S_W_P;
            S_W_P:      state_next = stat.idx_last ? S_O_RD : S_W_RD;
            S_O_RD:     state_next = S_O_DIV;
            S_O_DIV:    state_next = S_O_WAIT;
            S_O_WAIT:   if (stat.div_done) state_next = S_O_LOAD;
            S_O_LOAD:
            begin
                if (stat.out_free)
                    state_next = stat.idx_last ? S_CLEAR : S_O_RD;
            end
            S_CLEAR:    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        ctrl.in_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_MAT_WR:   ctrl.cmd = DP_MAT_WR;
            S_TERM_RD:  ctrl.cmd = DP_RD_ITEM;
            S_TERM_MUL: ctrl.cmd = DP_TERM_MUL;
            S_TERM_WR:  ctrl.cmd = DP_TERM_WR;
            S_CLOSE_RD: ctrl.cmd = DP_RD_ITEM;
            S_CLOSE_WR: ctrl.cmd = DP_CLOSE_WR;
            S_MAX_RD:   ctrl.cmd = DP_MAX_RD;
            S_MAX_UPD:  ctrl.cmd = DP_MAX_UPD;
            S_RHO:      ctrl.cmd = DP_RHO;
            S_W_RD:     ctrl.cmd = DP_W_RD;
            S_W_MUL:    ctrl.cmd = DP_W_MUL;
            S_W_DIV:    ctrl.cmd = DP_W_DIV;
            S_W_F:      ctrl.cmd = DP_W_F;
            S_W_P:      ctrl.cmd = DP_W_P;
            S_O_RD:     ctrl.cmd = DP_O_RD;
            S_O_DIV:    ctrl.cmd = DP_O_DIV;
            S_O_LOAD:   ctrl.cmd = DP_O_LOAD;
            S_CLEAR:    ctrl.cmd = DP_CLEAR;
            default:    ctrl.cmd = DP_NOP;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/core/mwu_checker.sv
// Checker: port-level assertions for the top level, with its bind.
`default_nettype none
module mwu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [24:0] weight,
    input logic [5:0]  weight_index,
    input logic [46:0] max_violation,
    input logic        last
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weight) &&
        $stable(weight_index) && $stable(max_violation) && $stable(last))
        else $error("result item changed while stalled");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weight <= 25'h1000000)
        else $error("weight above one");

    a_rho_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> max_violation != 47'd0)
        else $error("rho is zero");

    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken during finish sweep");
endmodule

bind multiplicative_weight_update mwu_checker u_mwu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (items.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .weight        (results.weight),
    .weight_index  (results.weight_index),
    .max_violation (results.max_violation),
    .last          (results.last)
);
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for multiplicative_weight_update: directed table, then random runs checked against a predictor.
module tb_top;
    import mwu_pkg::*;

    localparam longint VIOL_MAX = 64'sd140737488355327;
    localparam longint VIOL_MIN = -VIOL_MAX - 1;
    localparam int     SETTLE   = 200;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [IDX_W-1:0]    idx;
        logic [RHO_W-1:0]    rho;
        logic                last;
    } weight_res_t;

    typedef struct {
        op_t                 op;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [VAL_W-1:0]    value;
        logic [CI_W-1:0]     ci;
        logic [PRIOR_W-1:0]  prior;
        bit                  typed;
        logic [WEIGHT_W-1:0] t_weight;
        logic [RHO_W-1:0]    t_rho;
    } stim_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [STEP_W-1:0]   cfg_wdata;

    mwu_in_if  in_ch ();
    mwu_out_if out_ch ();

    multiplicative_weight_update uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (in_ch),
        .results   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    logic [VAL_W-1:0]   x_store [1024];
    longint             viol [64];
    logic [PRIOR_W-1:0] prior_mem [64];
    int                 closed_count;
    logic [STEP_W-1:0]  step;
    int                 x_written [$];
    weight_res_t        weight_q [$];
    stim_t              dir_tab [$];
    int                 errors;
    int                 tx_idle;
    int                 rx_idle;
    int                 rx_hold;
    int                 rand_items;

    function automatic longint sat48(longint v);
        if (v > VIOL_MAX)
            return VIOL_MAX;
        if (v < VIOL_MIN)
            return VIOL_MIN;
        return v;
    endfunction

    function automatic stim_t mk(op_t op, int row, int col, logic [31:0] value, int ci,
                                 logic [31:0] prior);
        stim_t s;
        s.op = op;
        s.row = ROW_W'(row);
        s.col = COL_W'(col);
        s.value = value;
        s.ci = CI_W'(ci);
        s.prior = prior;
        s.typed = 1'b0;
        s.t_weight = '0;
        s.t_rho = '0;
        return s;
    endfunction

    task automatic weight_update_predict(stim_t s);
        longint               x;
        longint               t;
        longint               q;
        longint               f;
        longint               p;
        longint               a;
        longint               maxabs;
        longint               rho;
        longint               eps;
        longint unsigned      at;
        longint unsigned      sum;
        longint unsigned      wv [64];
        weight_res_t          r;
        int                   i;
        case (s.op)
            OP_LOAD:
            begin
                x_store[{s.row, s.col}] = s.value;
            end
            OP_TERM:
            begin
                x = longint'($signed(x_store[{s.row, s.col}]));
                viol[s.ci] = sat48(viol[s.ci] + ((longint'($signed(s.value)) * x) >>> 16));
            end
            OP_CLOSE:
            begin
                viol[s.ci] = sat48(viol[s.ci] - longint'($signed(s.value)));
                prior_mem[s.ci] = s.prior;
                if (int'(s.ci) + 1 > closed_count)
                    closed_count = int'(s.ci) + 1;
            end
            default:
            begin
                eps = (step > EPS_MAX) ? 65536 : longint'(step);
                maxabs = 0;
                sum = 0;
                for (i = 0; i < closed_count; i++)
                begin
                    a = (viol[i] < 0) ? -viol[i] : viol[i];
                    if (a > maxabs)
                        maxabs = a;
                end
                rho = maxabs + 1;
                if (rho > VIOL_MAX)
                    rho = VIOL_MAX;
                for (i = 0; i < closed_count; i++)
                begin
                    t = viol[i] * eps;
                    at = (t < 0) ? (64'd0 - longint'(t)) : t;
                    q = longint'(at / longint'(rho));
                    if (t < 0)
                        q = -q;
                    f = 65536 - q;
                    p = longint'({32'b0, prior_mem[i]}) * f;
                    p = p >>> 16;
                    if (p < 1)
                        p = 1;
                    wv[i] = p;
                    sum += wv[i];
                end
                for (i = 0; i < closed_count; i++)
                begin
                    r.weight = WEIGHT_W'((wv[i] << 24) / sum);
                    r.idx = IDX_W'(i);
                    r.rho = RHO_W'(rho);
                    r.last = (i + 1 == closed_count);
                    weight_q.push_back(r);
                end
                for (i = 0; i < 64; i++)
                    viol[i] = 0;
                closed_count = 0;
            end
        endcase
    endtask

    task automatic send_item(stim_t s);
        weight_res_t r;
        while ($urandom_range(99) < tx_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= s.op;
        in_ch.row <= s.row;
        in_ch.col <= s.col;
        in_ch.value <= s.value;
        in_ch.constraint_index <= s.ci;
        in_ch.prior_weight <= s.prior;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        weight_update_predict(s);
        if (s.typed)
        begin
            r.weight = s.t_weight;
            r.idx = 0;
            r.rho = s.t_rho;
            r.last = 1'b1;
            void'(weight_q.pop_back());
            weight_q.push_back(r);
        end
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (weight_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_step(logic [STEP_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        step = v;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3, 4, 5: return $urandom_range(262143) - 131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_t rand_op();
        stim_t s;
        int    k;
        int    addr;
        int    ci;
        logic [31:0] pw;
        k = $urandom_range(99);
        ci = ($urandom_range(3) != 0) ? $urandom_range(7) : $urandom_range(63);
        case ($urandom_range(9))
            0: pw = 32'h0;
            1: pw = 32'hFFFF_FFFF;
            default: pw = $urandom;
        endcase
        if (k < 25 || x_written.size() == 0)
        begin
            addr = $urandom_range(1023);
            s = mk(OP_LOAD, addr >> 5, addr & 31, rand_value(), ci, pw);
        end
        else if (k < 65)
        begin
            addr = x_written[$urandom_range(x_written.size() - 1)];
            s = mk(OP_TERM, addr >> 5, addr & 31, rand_value(), ci, pw);
        end
        else if (k < 97)
            s = mk(OP_CLOSE, $urandom_range(31), $urandom_range(31), rand_value(), ci, pw);
        else
            s = mk(OP_FINISH, $urandom_range(31), $urandom_range(31), $urandom, ci, pw);
        return s;
    endfunction

    task automatic rand_run();
        stim_t s;
        int    n;
        int    k;
        n = $urandom_range(2, 12);
        for (k = 0; k < n; k++)
        begin
            s = rand_op();
            if (s.op == OP_LOAD)
                x_written.push_back(int'({s.row, s.col}));
            send_item(s);
            rand_items++;
        end
        if ($urandom_range(9) != 0)
        begin
            send_item(mk(OP_FINISH, $urandom_range(31), $urandom_range(31), $urandom,
                         $urandom_range(63), $urandom));
            rand_items++;
        end
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                rx_hold--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge clk)
    begin
        weight_res_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (weight_q.size() == 0)
            begin
                $display("%0t: unexpected result weight %0d index %0d", $time,
                         out_ch.weight, out_ch.weight_index);
                errors++;
            end
            else
            begin
                e = weight_q.pop_front();
                if (out_ch.weight !== e.weight)
                begin
                    $display("%0t: weight expected %0d actual %0d", $time, e.weight,
                             out_ch.weight);
                    errors++;
                end
                if (out_ch.weight_index !== e.idx)
                begin
                    $display("%0t: weight_index expected %0d actual %0d", $time, e.idx,
                             out_ch.weight_index);
                    errors++;
                end
                if (out_ch.max_violation !== e.rho)
                begin
                    $display("%0t: max_violation expected %0d actual %0d", $time, e.rho,
                             out_ch.max_violation);
                    errors++;
                end
                if (out_ch.last !== e.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, e.last,
                             out_ch.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        stim_t s;
        int    i;
        int    ph;
        errors = 0;
        rand_items = 0;
        rx_hold = 0;
        tx_idle = 7;
        rx_idle = 55;
        closed_count = 0;
        step = STEP_RESET;
        for (i = 0; i < 64; i++)
        begin
            viol[i] = 0;
            prior_mem[i] = '0;
        end
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD;
        in_ch.row = '0;
        in_ch.col = '0;
        in_ch.value = '0;
        in_ch.constraint_index = '0;
        in_ch.prior_weight = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // write every prior weight once so that no finish reads an empty slot
        for (i = 0; i < 64; i++)
            send_item(mk(OP_CLOSE, 0, 0, $urandom_range(65535), i, $urandom));

        dir_tab.push_back(mk(OP_FINISH, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(OP_FINISH, 31, 31, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF));
        dir_tab.push_back(mk(OP_CLOSE, 0, 0, 0, 0, 32'h0001_0000));
        s = mk(OP_FINISH, 0, 0, 0, 0, 0);
        s.typed = 1'b1;
        s.t_weight = 25'd16777216;
        s.t_rho = 47'd1;
        dir_tab.push_back(s);
        dir_tab.push_back(mk(OP_LOAD, 0, 0, 32'h7FFF_FFFF, 0, 0));
        dir_tab.push_back(mk(OP_LOAD, 31, 31, 32'h8000_0000, 0, 0));
        dir_tab.push_back(mk(OP_LOAD, 0, 31, 32'h0001_0000, 0, 0));
        dir_tab.push_back(mk(OP_LOAD, 31, 0, 32'hFFFF_0000, 0, 0));
        dir_tab.push_back(mk(OP_TERM, 0, 0, 32'h8000_0000, 63, 0));
        dir_tab.push_back(mk(OP_TERM, 31, 31, 32'h8000_0000, 63, 0));
        dir_tab.push_back(mk(OP_TERM, 31, 31, 32'h8000_0000, 63, 0));
        dir_tab.push_back(mk(OP_TERM, 31, 31, 32'h8000_0000, 63, 0));
        dir_tab.push_back(mk(OP_TERM, 31, 31, 32'h8000_0000, 63, 0));
        dir_tab.push_back(mk(OP_TERM, 0, 31, 32'h0001_0000, 0, 0));
        dir_tab.push_back(mk(OP_TERM, 31, 0, 32'h7FFF_FFFF, 1, 0));
        dir_tab.push_back(mk(OP_CLOSE, 0, 0, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF));
        dir_tab.push_back(mk(OP_CLOSE, 0, 0, 32'h8000_0000, 63, 32'h0));
        dir_tab.push_back(mk(OP_CLOSE, 0, 0, 32'h0, 31, 32'd12345));
        dir_tab.push_back(mk(OP_FINISH, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(OP_CLOSE, 0, 0, 32'hFFFF_8000, 2, 32'h0002_0000));
        dir_tab.push_back(mk(OP_FINISH, 0, 0, 0, 0, 0));
        foreach (dir_tab[i])
            send_item(dir_tab[i]);
        x_written.push_back(0);
        x_written.push_back(1023);
        x_written.push_back(31);
        x_written.push_back(992);
        drain();

        for (ph = 0; ph < 3; ph++)
        begin
            tx_idle = (ph == 0) ? 7 : (ph == 1) ? 55 : 0;
            rx_idle = (ph == 0) ? 55 : (ph == 1) ? 7 : 0;
            case (ph)
                0: write_step(17'd65536);
                1: write_step(17'h1FFFF);
                default: write_step(17'd0);
            endcase
            if (ph == 0)
                rx_hold = 20000;
            while (rand_items < (ph + 1) * 15)
            begin
                rand_run();
                if ($urandom_range(2) == 0)
                begin
                    drain();
                    write_step(STEP_W'($urandom_range(131071)));
                end
            end
            drain();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
